// ===== rtl/qrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, result codes and stage types shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH  = 16;
    localparam int PROD_WIDTH  = 2 * COEF_WIDTH;
    localparam int DISC_WIDTH  = 2 * COEF_WIDTH + 1;
    localparam int RAD_WIDTH   = DISC_WIDTH + 32;
    localparam int ROOT_WIDTH  = (RAD_WIDTH + 1) / 2;
    localparam int RADP_WIDTH  = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH   = ROOT_WIDTH + 3;
    localparam int NUM_WIDTH   = COEF_WIDTH + 19;
    localparam int NMAG_WIDTH  = COEF_WIDTH + 18;
    localparam int DEN_WIDTH   = COEF_WIDTH + 1;
    localparam int DREM_WIDTH  = DEN_WIDTH + 1;
    localparam int QX_WIDTH    = (NMAG_WIDTH > 33) ? NMAG_WIDTH : 33;

    localparam logic [1:0] ST_REAL    = 2'd0;
    localparam logic [1:0] ST_COMPLEX = 2'd1;
    localparam logic [1:0] ST_AZERO   = 2'd2;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic [PROD_WIDTH-1:0]        b2;
        logic [PROD_WIDTH-1:0]        ac;
        logic                         opp_sign;
        logic                         a_zero;
    } mul_stage_t;

    typedef struct packed {
        logic [RADP_WIDTH-1:0]        rad;
        logic [ROOT_WIDTH-1:0]        root;
        logic [REM_WIDTH-1:0]         rem;
        logic signed [COEF_WIDTH-1:0] a;
        logic signed [COEF_WIDTH-1:0] b;
        logic                         neg_d;
        logic                         a_zero;
    } sq_stage_t;

    typedef struct packed {
        logic [NMAG_WIDTH-1:0] work1;
        logic [DEN_WIDTH-1:0]  rem1;
        logic [NMAG_WIDTH-1:0] work2;
        logic [DEN_WIDTH-1:0]  rem2;
        logic [DEN_WIDTH-1:0]  den;
        logic                  neg1;
        logic                  neg2;
        logic                  neg_d;
        logic                  a_zero;
    } div_stage_t;

    typedef struct packed {
        logic [31:0] r1;
        logic [31:0] r2;
        logic [30:0] im;
        logic [1:0]  status;
        logic        sat;
    } result_t;

endpackage

// ===== rtl/quadratic_root_solver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Pipelined fixed-point solver for the roots of a*x^2 + b*x + c.
// ----------------------------------------------------------------------------
// One coefficient set is taken per cycle while the skid entry is empty, and each
// gives one result. The pipeline has one multiply stage, one discriminant stage,
// one square-root stage per root bit, one numerator stage and one divider
// stage per quotient bit, with both dividers running side by side. A
// two-entry output buffer keeps inputs flowing while one result waits; the
// pipeline stalls while its second (skid) entry is full.
module quadratic_root_solver_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [qrs_pkg::COEF_WIDTH-1:0]   coef_a,
    input  logic [qrs_pkg::COEF_WIDTH-1:0]   coef_b,
    input  logic [qrs_pkg::COEF_WIDTH-1:0]   coef_c,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               root1_real,
    output logic signed [31:0]               root2_real,
    output logic [30:0]                      imag_magnitude,
    output logic [1:0]                       root_status,
    output logic                             saturated
);
    import qrs_pkg::*;

    localparam int NST = 3 + ROOT_WIDTH + NMAG_WIDTH;

    logic [NST-1:0]           valid_reg;
    mul_stage_t               mul_reg, mul_next;
    sq_stage_t                sq_reg   [ROOT_WIDTH+1];
    sq_stage_t                sq_next  [ROOT_WIDTH+1];
    div_stage_t               dv_reg   [NMAG_WIDTH+1];
    div_stage_t               dv_next  [NMAG_WIDTH+1];
    result_t                  res_next, out_reg, skid_reg;
    logic                     out_v_reg, skid_v_reg;
    logic                     en, pop, last_v;

    assign en       = !skid_v_reg;
    assign in_ready = en;
    assign pop      = out_v_reg && out_ready;
    assign last_v   = valid_reg[NST-1];

    // multiply stage
    always_comb
    begin
        logic [COEF_WIDTH-1:0] ma, mb, mc;
        ma = coef_a[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_a) : coef_a;
        mb = coef_b[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_b) : coef_b;
        mc = coef_c[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_c) : coef_c;
        mul_next.a        = coef_a;
        mul_next.b        = coef_b;
        mul_next.b2       = PROD_WIDTH'(mb) * PROD_WIDTH'(mb);
        mul_next.ac       = PROD_WIDTH'(ma) * PROD_WIDTH'(mc);
        mul_next.opp_sign = coef_a[COEF_WIDTH-1] ^ coef_c[COEF_WIDTH-1];
        mul_next.a_zero   = (coef_a == '0);
    end

    // discriminant stage seeds the root extraction, then one root bit per stage
    always_comb
    begin
        logic [DISC_WIDTH:0] b2e, ac4, d;
        logic                neg;
        b2e = (DISC_WIDTH+1)'(mul_reg.b2);
        ac4 = {mul_reg.ac, 2'b00};
        neg = 1'b0;
        if (mul_reg.opp_sign)
            d = b2e + ac4;
        else if (ac4 <= b2e)
            d = b2e - ac4;
        else
        begin
            d   = ac4 - b2e;
            neg = 1'b1;
        end
        sq_next[0].rad    = RADP_WIDTH'({d[DISC_WIDTH-1:0], 32'd0});
        sq_next[0].root   = '0;
        sq_next[0].rem    = '0;
        sq_next[0].a      = mul_reg.a;
        sq_next[0].b      = mul_reg.b;
        sq_next[0].neg_d  = neg;
        sq_next[0].a_zero = mul_reg.a_zero;

        for (int k = 1; k <= ROOT_WIDTH; k++)
        begin
            logic [REM_WIDTH-1:0] rt, trial;
            rt    = {sq_reg[k-1].rem[REM_WIDTH-3:0], sq_reg[k-1].rad[RADP_WIDTH-1 -: 2]};
            trial = REM_WIDTH'({sq_reg[k-1].root, 2'b01});
            sq_next[k] = sq_reg[k-1];
            sq_next[k].rad = {sq_reg[k-1].rad[RADP_WIDTH-3:0], 2'b00};
            if (rt >= trial)
            begin
                sq_next[k].rem  = rt - trial;
                sq_next[k].root = {sq_reg[k-1].root[ROOT_WIDTH-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = rt;
                sq_next[k].root = {sq_reg[k-1].root[ROOT_WIDTH-2:0], 1'b0};
            end
        end
    end

    // numerators and denominator magnitude, then one quotient bit per stage
    // for both dividers
    always_comb
    begin
        logic signed [NUM_WIDTH-1:0] bx, nb, sx, n1, n2, ax, am;
        sq_stage_t q;
        q  = sq_reg[ROOT_WIDTH];
        bx = NUM_WIDTH'(q.b);
        nb = -(bx <<< 16);
        sx = NUM_WIDTH'(q.root);
        n1 = q.neg_d ? nb : nb + sx;
        n2 = q.neg_d ? sx : nb - sx;
        ax = NUM_WIDTH'(q.a);
        am = ax[NUM_WIDTH-1] ? -ax : ax;
        dv_next[0].work1  = NMAG_WIDTH'(n1[NUM_WIDTH-1] ? -n1 : n1);
        dv_next[0].work2  = NMAG_WIDTH'(n2[NUM_WIDTH-1] ? -n2 : n2);
        dv_next[0].rem1   = '0;
        dv_next[0].rem2   = '0;
        dv_next[0].den    = DEN_WIDTH'(am <<< 1);
        dv_next[0].neg1   = n1[NUM_WIDTH-1] ^ q.a[COEF_WIDTH-1];
        dv_next[0].neg2   = n2[NUM_WIDTH-1] ^ q.a[COEF_WIDTH-1];
        dv_next[0].neg_d  = q.neg_d;
        dv_next[0].a_zero = q.a_zero;

        for (int k = 1; k <= NMAG_WIDTH; k++)
        begin
            logic [DREM_WIDTH-1:0] r1, r2, dd;
            dd = DREM_WIDTH'(dv_reg[k-1].den);
            r1 = {dv_reg[k-1].rem1, dv_reg[k-1].work1[NMAG_WIDTH-1]};
            r2 = {dv_reg[k-1].rem2, dv_reg[k-1].work2[NMAG_WIDTH-1]};
            dv_next[k] = dv_reg[k-1];
            if (r1 >= dd)
            begin
                dv_next[k].rem1  = DEN_WIDTH'(r1 - dd);
                dv_next[k].work1 = {dv_reg[k-1].work1[NMAG_WIDTH-2:0], 1'b1};
            end
            else
            begin
                dv_next[k].rem1  = DEN_WIDTH'(r1);
                dv_next[k].work1 = {dv_reg[k-1].work1[NMAG_WIDTH-2:0], 1'b0};
            end
            if (r2 >= dd)
            begin
                dv_next[k].rem2  = DEN_WIDTH'(r2 - dd);
                dv_next[k].work2 = {dv_reg[k-1].work2[NMAG_WIDTH-2:0], 1'b1};
            end
            else
            begin
                dv_next[k].rem2  = DEN_WIDTH'(r2);
                dv_next[k].work2 = {dv_reg[k-1].work2[NMAG_WIDTH-2:0], 1'b0};
            end
        end
    end

    function automatic logic [32:0] clamp_real(logic [QX_WIDTH-1:0] q, logic neg);
        logic [32:0] r;
        if (!neg)
        begin
            if (q > QX_WIDTH'(33'h07FFFFFFF))
                r = {1'b1, 32'h7FFFFFFF};
            else
                r = {1'b0, q[31:0]};
        end
        else
        begin
            if (q > QX_WIDTH'(33'h080000000))
                r = {1'b1, 32'h80000000};
            else
                r = {1'b0, 32'(-q[31:0])};
        end
        return r;
    endfunction

    // sign fix and clamp
    always_comb
    begin
        logic [QX_WIDTH-1:0] q1, q2;
        logic [32:0]         c1, c2;
        div_stage_t          t;
        t  = dv_reg[NMAG_WIDTH];
        q1 = QX_WIDTH'(t.work1);
        q2 = QX_WIDTH'(t.work2);
        c1 = clamp_real(q1, t.neg1);
        c2 = clamp_real(q2, t.neg2);
        res_next = '0;
        if (t.a_zero)
            res_next.status = ST_AZERO;
        else if (t.neg_d)
        begin
            res_next.status = ST_COMPLEX;
            res_next.r1     = c1[31:0];
            res_next.r2     = c1[31:0];
            if (q2 > QX_WIDTH'(33'h07FFFFFFF))
            begin
                res_next.im  = 31'h7FFFFFFF;
                res_next.sat = 1'b1;
            end
            else
            begin
                res_next.im  = q2[30:0];
                res_next.sat = c1[32];
            end
        end
        else
        begin
            res_next.status = ST_REAL;
            res_next.r1     = c1[31:0];
            res_next.r2     = c2[31:0];
            res_next.sat    = c1[32] | c2[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
            for (int k = 0; k <= ROOT_WIDTH; k++)
                sq_reg[k] <= sq_next[k];
            for (int k = 0; k <= NMAG_WIDTH; k++)
                dv_reg[k] <= dv_next[k];
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (pop)
                skid_v_reg <= 1'b0;
        end
        else if (last_v)
        begin
            if (out_v_reg && !pop)
                skid_v_reg <= 1'b1;
            else
                out_v_reg <= 1'b1;
        end
        else if (pop)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (last_v)
        begin
            if (out_v_reg && !pop)
                skid_reg <= res_next;
            else
                out_reg <= res_next;
        end
    end

    assign out_valid      = out_v_reg;
    assign root1_real     = out_reg.r1;
    assign root2_real     = out_reg.r2;
    assign imag_magnitude = out_reg.im;
    assign root_status    = out_reg.status;
    assign saturated      = out_reg.sat;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without output entry");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && !out_ready |=> skid_v_reg)
        else $error("skid entry dropped while output stalled");

    a_azero_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_status == ST_AZERO |->
            root1_real == 0 && root2_real == 0 && imag_magnitude == 0 && !saturated)
        else $error("nonzero result for zero a");

    a_real_no_imag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_status == ST_REAL |-> imag_magnitude == 0)
        else $error("imaginary part on real roots");

endmodule
